// File: rtl/windowed_dtw_distance_assert.svh
// Assertion macros shared by the windowed DTW distance RTL.
`ifndef WINDOWED_DTW_DISTANCE_ASSERT_SVH
`define WINDOWED_DTW_DISTANCE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WDTW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wdtw assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define WDTW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wdtw assertion failed");

`endif

// File: rtl/wdtw_pkg.sv
// Package with constants, register indexes and types of the windowed DTW distance block.
`default_nettype none
package wdtw_pkg;
   localparam int MAX_LENGTH_DEFAULT  = 256;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int DIST_BITS           = 48;
   localparam int LENGTH_REG_BITS     = 9;
   localparam int FRACTION_BITS       = 17;
   localparam int FRACTION_SHIFT      = 16;
   localparam int CSR_DATA_BITS       = 17;

   localparam logic [DIST_BITS-1:0]       DIST_MAX         = '1;
   localparam logic [LENGTH_REG_BITS-1:0] LENGTH_RESET     = 9'd256;
   localparam logic [FRACTION_BITS-1:0]   FRACTION_RESET   = 17'd3277;

   typedef enum logic {
      CSR_SERIES_LENGTH   = 1'b0,
      CSR_WINDOW_FRACTION = 1'b1
   } wdtw_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROW,
      ST_FIRST,
      ST_READ,
      ST_COST,
      ST_CELL,
      ST_ROWEND,
      ST_EMIT
   } wdtw_state_type;
endpackage
`default_nettype wire

// File: rtl/wdtw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wdtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/windowed_dtw_distance.sv
// Flow: n load transactions at one per cycle, then SETUP and, per row, ROW, FIRST,
// READ, COST and CELL for each band cell, and ROWEND; then EMIT presents the result.
// Throughput: one job at a time; the row loop over one shared cost/add unit sets it.
// The row store is read and written in place, with the band limits of the previous row
// telling which cells are live, so no clearing pass is needed after reset.
// Reset is synchronous and active high; it clears control state and the configuration registers.
`default_nettype none
module windowed_dtw_distance #(
   parameter int MAX_LENGTH  = wdtw_pkg::MAX_LENGTH_DEFAULT,
   parameter int SAMPLE_BITS = wdtw_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_query_value,
   input  wire logic [7:0]                           req_query_position,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_series_value,
   input  wire logic [wdtw_pkg::DIST_BITS-1:0]       req_abandon_threshold,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [wdtw_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic                                      rsp_abandoned,
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_index,
   input  wire logic [wdtw_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   localparam int LW   = $clog2(MAX_LENGTH + 1);
   localparam int QAW  = $clog2(MAX_LENGTH);
   localparam int DB   = wdtw_pkg::DIST_BITS;
   localparam int DW   = SAMPLE_BITS + 1;
   localparam int SQW  = 2 * DW;

   wdtw_pkg::wdtw_state_type state_ff, state_in;

   logic [wdtw_pkg::LENGTH_REG_BITS-1:0] len_cfg_ff;
   logic [wdtw_pkg::FRACTION_BITS-1:0]   frac_cfg_ff;
   logic [LW-1:0] load_count_ff, load_count_in;
   logic [LW-1:0] n_ff, w_ff, row_ff, j_ff, plo_ff, phi_ff;
   logic          first_row_ff;
   logic [DB-1:0] thr_ff, left_ff, rowmin_ff, prevj_ff, prevj1_ff, best_ff, sq_ff;
   logic [DB-1:0] res_dist_ff;
   logic          res_ab_ff;
   logic          rsp_valid_ff, rsp_abandoned_ff;
   logic [DB-1:0] rsp_distance_ff;

   logic [LW-1:0] n_eff, lo_c, hi_c, guard_addr, row_rd_addr, j_next;
   logic [LW:0]   hi_sum;
   logic [DB-1:0] guard_val, cell_c, row_rd_data, best_c;
   logic [SAMPLE_BITS-1:0] q_rd_data, s_rd_data;
   logic          req_fire, load_done, emit_fire, row_wr_en, q_wr_en;
   logic [QAW-1:0] q_wr_addr, s_rd_addr;
   logic [wdtw_pkg::FRACTION_BITS+LW-1:0] w_prod;
   logic [LW-1:0] w_shift;
   logic signed [DW-1:0] diff_c;
   logic [DW-1:0]  abs_c;
   logic [SQW-1:0] sq_c;
   logic [63:0]    sq_wide;
   logic [DB:0]    sum_c;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff  <= wdtw_pkg::LENGTH_RESET;
         frac_cfg_ff <= wdtw_pkg::FRACTION_RESET;
      end else if (csr_write_enable) begin
         unique case (wdtw_pkg::wdtw_csr_type'(csr_index))
            wdtw_pkg::CSR_SERIES_LENGTH: begin
               len_cfg_ff <= csr_write_data[wdtw_pkg::LENGTH_REG_BITS-1:0];
            end
            wdtw_pkg::CSR_WINDOW_FRACTION: begin
               frac_cfg_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (len_cfg_ff == '0) begin
         n_eff = LW'(1);
      end else if (32'(len_cfg_ff) > 32'(MAX_LENGTH)) begin
         n_eff = LW'(MAX_LENGTH);
      end else begin
         n_eff = LW'(len_cfg_ff);
      end
   end

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != wdtw_pkg::ST_IDLE);
   assign load_done = (32'(load_count_ff) + 32'd1) >= 32'(n_eff);
   assign q_wr_en   = req_fire && (32'(req_query_position) < 32'(MAX_LENGTH));
   assign q_wr_addr = QAW'(req_query_position);
   assign load_count_in = load_done ? '0 : LW'(32'(load_count_ff) + 32'd1);

   // Band limits of the current row.
   assign lo_c   = (row_ff > w_ff) ? LW'(row_ff - w_ff) : '0;
   assign hi_sum = (LW+1)'(row_ff) + (LW+1)'(w_ff);
   assign hi_c   = (hi_sum > (LW+1)'(n_ff - 1'b1)) ? LW'(n_ff - 1'b1) : LW'(hi_sum);
   assign j_next = LW'((LW+1)'(j_ff) + (LW+1)'(1));

   // Cells of the previous row outside its band read as the saturated maximum.
   assign guard_addr = (state_ff == wdtw_pkg::ST_FIRST) ? j_ff : j_next;
   always_comb begin
      if (first_row_ff) begin
         guard_val = (guard_addr == '0) ? '0 : wdtw_pkg::DIST_MAX;
      end else if (((LW+1)'(guard_addr) >= (LW+1)'(plo_ff) + (LW+1)'(1)) &&
                   ((LW+1)'(guard_addr) <= (LW+1)'(phi_ff) + (LW+1)'(1))) begin
         guard_val = row_rd_data;
      end else begin
         guard_val = wdtw_pkg::DIST_MAX;
      end
   end

   // Shared cost unit: squared difference, min of the three neighbors and their saturating sum.
   assign diff_c  = DW'(signed'(q_rd_data)) - DW'(signed'(s_rd_data));
   assign abs_c   = diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);
   assign sq_c    = SQW'(abs_c) * SQW'(abs_c);
   assign sq_wide = 64'(sq_c);
   always_comb begin
      best_c = prevj_ff;
      if (guard_val < best_c) begin
         best_c = guard_val;
      end
      if (left_ff < best_c) begin
         best_c = left_ff;
      end
   end
   assign sum_c  = (DB+1)'(sq_ff) + (DB+1)'(best_ff);
   assign cell_c = sum_c[DB] ? wdtw_pkg::DIST_MAX : sum_c[DB-1:0];

   assign w_prod  = (wdtw_pkg::FRACTION_BITS+LW)'(frac_cfg_ff) *
                    (wdtw_pkg::FRACTION_BITS+LW)'(n_ff);
   assign w_shift = LW'(w_prod >> wdtw_pkg::FRACTION_SHIFT);

   assign emit_fire = (state_ff == wdtw_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wdtw_pkg::ST_IDLE:   if (req_fire && load_done) state_in = wdtw_pkg::ST_SETUP;
         wdtw_pkg::ST_SETUP:  state_in = wdtw_pkg::ST_ROW;
         wdtw_pkg::ST_ROW:    state_in = wdtw_pkg::ST_FIRST;
         wdtw_pkg::ST_FIRST:  state_in = wdtw_pkg::ST_READ;
         wdtw_pkg::ST_READ:   state_in = wdtw_pkg::ST_COST;
         wdtw_pkg::ST_COST:   state_in = wdtw_pkg::ST_CELL;
         wdtw_pkg::ST_CELL: begin
            state_in = (j_ff == hi_c) ? wdtw_pkg::ST_ROWEND : wdtw_pkg::ST_READ;
         end
         wdtw_pkg::ST_ROWEND: begin
            if ((rowmin_ff > thr_ff) || (row_ff == LW'(n_ff - 1'b1))) begin
               state_in = wdtw_pkg::ST_EMIT;
            end else begin
               state_in = wdtw_pkg::ST_ROW;
            end
         end
         wdtw_pkg::ST_EMIT:   if (emit_fire) state_in = wdtw_pkg::ST_IDLE;
         default:             state_in = wdtw_pkg::ST_IDLE;
      endcase
   end

   // Memory controls.
   always_comb begin
      row_rd_addr = j_next;
      row_wr_en   = 1'b0;
      unique case (state_ff)
         wdtw_pkg::ST_ROW:  row_rd_addr = lo_c;
         wdtw_pkg::ST_CELL: row_wr_en   = 1'b1;
         default: begin
         end
      endcase
   end
   assign s_rd_addr = j_ff[QAW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wdtw_pkg::ST_IDLE;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit_fire || (rsp_valid_ff && rsp_stall);
         if (req_fire) begin
            load_count_ff <= load_count_in;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_distance_ff  <= res_dist_ff;
         rsp_abandoned_ff <= res_ab_ff;
      end
      unique case (state_ff)
         wdtw_pkg::ST_IDLE: begin
            if (req_fire && load_done) begin
               thr_ff <= req_abandon_threshold;
               n_ff   <= n_eff;
            end
         end
         wdtw_pkg::ST_SETUP: begin
            w_ff         <= (w_shift > n_ff) ? n_ff : w_shift;
            row_ff       <= '0;
            first_row_ff <= 1'b1;
         end
         wdtw_pkg::ST_ROW: begin
            j_ff      <= lo_c;
            left_ff   <= wdtw_pkg::DIST_MAX;
            rowmin_ff <= wdtw_pkg::DIST_MAX;
         end
         wdtw_pkg::ST_FIRST: begin
            prevj_ff <= guard_val;
         end
         wdtw_pkg::ST_COST: begin
            sq_ff     <= (sq_wide > 64'(wdtw_pkg::DIST_MAX)) ? wdtw_pkg::DIST_MAX
                                                            : sq_wide[DB-1:0];
            best_ff   <= best_c;
            prevj1_ff <= guard_val;
         end
         wdtw_pkg::ST_CELL: begin
            left_ff  <= cell_c;
            prevj_ff <= prevj1_ff;
            if (cell_c < rowmin_ff) begin
               rowmin_ff <= cell_c;
            end
            if (j_ff != hi_c) begin
               j_ff <= j_next;
            end
         end
         wdtw_pkg::ST_ROWEND: begin
            plo_ff       <= lo_c;
            phi_ff       <= hi_c;
            first_row_ff <= 1'b0;
            row_ff       <= LW'((LW+1)'(row_ff) + (LW+1)'(1));
            if (rowmin_ff > thr_ff) begin
               res_dist_ff <= rowmin_ff;
               res_ab_ff   <= 1'b1;
            end else begin
               res_dist_ff <= left_ff;
               res_ab_ff   <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   wdtw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LENGTH)) u_query_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (req_query_value),
      .rd_addr (row_ff[QAW-1:0]),
      .rd_data (q_rd_data)
   );

   wdtw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LENGTH)) u_series_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (load_count_ff[QAW-1:0]),
      .wr_data (req_series_value),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   wdtw_ram #(.WIDTH(DB), .DEPTH(MAX_LENGTH + 1)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (j_next),
      .wr_data (cell_c),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_abandoned = rsp_abandoned_ff;

`include "windowed_dtw_distance_assert.svh"
   `WDTW_ASSERT_NOW(a_cell_in_band, state_ff == wdtw_pkg::ST_CELL, (j_ff >= lo_c) && (j_ff <= hi_c))
   `WDTW_ASSERT_NOW(a_row_in_range, state_ff == wdtw_pkg::ST_ROWEND, row_ff < n_ff)
   `WDTW_ASSERT_NEXT(a_hold_pending, (state_ff == wdtw_pkg::ST_EMIT) && rsp_valid_ff && rsp_stall, state_ff == wdtw_pkg::ST_EMIT)
endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the windowed DTW distance block.
`default_nettype none
module testbench;

   localparam int NUM_ITEMS  = 1800;
   localparam int CYCLE_CAP  = 4000000;
   localparam int SETTLE     = 40;
   localparam int HOLD_LEN   = 400;

   typedef struct {
      logic signed [15:0] query_value;
      logic [7:0]         query_position;
      logic signed [15:0] series_value;
      logic [47:0]        abandon_threshold;
   } sample_pair_type;

   typedef struct {
      logic [47:0] distance;
      logic        abandoned;
   } warp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_query_value = '0;
   logic [7:0] req_query_position = '0;
   logic signed [15:0] req_series_value = '0;
   logic [47:0] req_abandon_threshold = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [47:0] rsp_distance;
   logic rsp_abandoned;
   logic csr_write_enable = 1'b0;
   wdtw_pkg::wdtw_csr_type csr_index = wdtw_pkg::CSR_SERIES_LENGTH;
   logic [wdtw_pkg::CSR_DATA_BITS-1:0] csr_write_data = '0;

   windowed_dtw_distance dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_query_value(req_query_value), .req_query_position(req_query_position),
      .req_series_value(req_series_value), .req_abandon_threshold(req_abandon_threshold),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance), .rsp_abandoned(rsp_abandoned),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   sample_pair_type pending_pairs[$];
   warp_result_type expected_distances[$];
   int error_count = 0;
   int sender_gap = 0;
   int receiver_wait = 0;
   int hold_left = 0;
   bit hold_armed = 0;
   bit hold_done = 0;
   bit idling_on = 0;
   int items_queued = 0;
   longint unsigned cycle_count = 0;

   // Mirror of the block's state.
   int query_mirror[256];
   int series_mirror[256];
   int load_index = 0;
   int length_reg = 256;
   int fraction_reg = 3277;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
   endtask

   function automatic longint unsigned add_saturated(longint unsigned a,
                                                     longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'(wdtw_pkg::DIST_MAX)) ? 64'(wdtw_pkg::DIST_MAX) : s;
   endfunction

   // Banded warping sweep with abandoning on the row minimum.
   function automatic warp_result_type compute_warp(longint unsigned threshold);
      longint unsigned prev_row[0:256];
      longint unsigned cur_row[0:256];
      longint unsigned best, cell_cost, row_min, diff, band_w;
      warp_result_type res;
      int n, lo, hi;
      n = (length_reg == 0) ? 1 : ((length_reg > 256) ? 256 : length_reg);
      band_w = (longint'(fraction_reg) * n) >> 16;
      if (band_w > n) band_w = n;
      foreach (prev_row[j]) prev_row[j] = wdtw_pkg::DIST_MAX;
      prev_row[0] = 0;
      for (int i = 0; i < n; i++) begin
         lo = (i > band_w) ? i - int'(band_w) : 0;
         hi = i + int'(band_w);
         if (hi > n - 1) hi = n - 1;
         row_min = wdtw_pkg::DIST_MAX;
         foreach (cur_row[j]) cur_row[j] = wdtw_pkg::DIST_MAX;
         for (int j = lo; j <= hi; j++) begin
            best = prev_row[j];
            if (prev_row[j+1] < best) best = prev_row[j+1];
            if (cur_row[j] < best) best = cur_row[j];
            diff = (query_mirror[i] > series_mirror[j]) ? query_mirror[i] - series_mirror[j]
                                                         : series_mirror[j] - query_mirror[i];
            cell_cost = add_saturated(diff * diff, best);
            cur_row[j+1] = cell_cost;
            if (cell_cost < row_min) row_min = cell_cost;
         end
         prev_row = cur_row;
         if (row_min > threshold) begin
            res.distance = row_min[47:0];
            res.abandoned = 1'b1;
            return res;
         end
      end
      res.distance = prev_row[n][47:0];
      res.abandoned = 1'b0;
      return res;
   endfunction

   function automatic void predict_transaction(sample_pair_type p);
      int n;
      query_mirror[p.query_position] = p.query_value;
      series_mirror[load_index] = p.series_value;
      load_index++;
      n = (length_reg == 0) ? 1 : ((length_reg > 256) ? 256 : length_reg);
      if (load_index >= n) begin
         load_index = 0;
         expected_distances.push_back(compute_warp(p.abandon_threshold));
      end
   endfunction

   // Driver: presents queued transactions, with a random gap between them when idling is on.
   always @(posedge clock) begin
      sample_pair_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            predict_transaction(sample_pair_type'{req_query_value, req_query_position,
                                                  req_series_value, req_abandon_threshold});
            sender_gap = idling_on ? $urandom_range(0, 14) : 0;
         end
         if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            p = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_query_value <= p.query_value;
            req_query_position <= p.query_position;
            req_series_value <= p.series_value;
            req_abandon_threshold <= p.abandon_threshold;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transaction and drives the stall.
   always @(posedge clock) begin
      warp_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end else if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_distances.size() == 0) begin
               report_mismatch("unexpected result", rsp_distance, 0);
            end else begin
               want = expected_distances.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_abandoned !== want.abandoned)
                  report_mismatch("abandoned", rsp_abandoned, want.abandoned);
            end
            receiver_wait = idling_on ? $urandom_range(0, 14) : 0;
         end
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_wait > 0) begin
            receiver_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return wdtw_pkg::DIST_MAX;
         2: return {16'($urandom), 32'($urandom)};
         default: return 48'($urandom) * $urandom_range(1, 6);
      endcase
   endfunction

   // Queues one job of count transactions; ordered gives a proper permutation.
   task automatic queue_job(input int count, input bit ordered, input logic [47:0] thr);
      int order[$];
      sample_pair_type p;
      for (int k = 0; k < count; k++) order.push_back(k);
      order.shuffle();
      for (int k = 0; k < count; k++) begin
         p.query_value = pick_sample();
         p.query_position = ordered ? 8'(order[k]) : 8'($urandom);
         p.series_value = pick_sample();
         p.abandon_threshold = (k == count - 1) ? thr : {16'($urandom), 32'($urandom)};
         pending_pairs.push_back(p);
      end
      items_queued += count;
   endtask

   task automatic wait_quiet();
      while (pending_pairs.size() != 0 || req_valid || expected_distances.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // The enable drops for one cycle so back-to-back writes never collide.
   task automatic write_register(input wdtw_pkg::wdtw_csr_type which, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= which;
      csr_write_data <= wdtw_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (which == wdtw_pkg::CSR_SERIES_LENGTH) length_reg = value & 'h1ff;
      else fraction_reg = value & 'h1ffff;
      @(posedge clock);
   endtask

   task automatic set_band(input int len, input int frac);
      wait_quiet();
      write_register(wdtw_pkg::CSR_SERIES_LENGTH, len);
      write_register(wdtw_pkg::CSR_WINDOW_FRACTION, frac);
   endtask

   function automatic int job_size();
      return (length_reg == 0) ? 1 : ((length_reg > 256) ? 256 : length_reg);
   endfunction

   initial begin
      int len, frac, phase;
      sample_pair_type p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A full-length job at reset settings writes every query entry once.
      queue_job(256, 1, wdtw_pkg::DIST_MAX);

      set_band(4, 65536);
      for (int k = 0; k < 4; k++) begin
         p = '{16'sh8000, 8'(k), 16'sh7fff, wdtw_pkg::DIST_MAX};
         pending_pairs.push_back(p);
      end
      queue_job(4, 1, '0);
      set_band(0, 0);
      queue_job(1, 0, '0);
      queue_job(1, 0, wdtw_pkg::DIST_MAX);
      // Shrinking the length after a partial load completes the job on the next item.
      set_band(8, 131071);
      queue_job(5, 0, wdtw_pkg::DIST_MAX);
      wait_quiet();
      write_register(wdtw_pkg::CSR_SERIES_LENGTH, 3);
      queue_job(1, 0, pick_threshold());

      idling_on = 1;
      set_band(511, 0);
      queue_job(256, 0, pick_threshold());
      set_band(256, 65536);
      queue_job(256, 0, wdtw_pkg::DIST_MAX);

      phase = 0;
      while (items_queued < NUM_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         case ($urandom_range(0, 4))
            0: frac = 0;
            1: frac = 65536;
            2: frac = 131071;
            default: frac = $urandom_range(0, 131071);
         endcase
         set_band(len, frac);
         idling_on = phase[0];
         if (phase == 3) hold_armed = 1;
         for (int j = 0; j < 8; j++)
            queue_job(job_size(), $urandom_range(0, 3) == 0, pick_threshold());
         phase++;
      end

      wait_quiet();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
